// ===== rtl/stq_pkg.sv =====
package stq_pkg;

    // ring geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    typedef logic [IDX_W-1:0] idx_t;

    // operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_TX_READY = 2'd1,
        OP_RX_BYTE  = 2'd2
    } op_t;

    // one transfer descriptor as held in the ring memory
    typedef struct packed {
        logic [31:0] base;
        logic [15:0] length;
        logic [2:0]  sel;
        logic [15:0] send_pos;
        logic [15:0] recv_pos;
        logic        active;
    } entry_t;

    // one result item
    typedef struct packed {
        logic        enqueue_accepted;
        logic        queue_full;
        logic        fetch_valid;
        logic [31:0] fetch_address;
        logic        store_valid;
        logic [31:0] store_address;
        logic [7:0]  store_data;
        logic        select_assert;
        logic        select_release;
        logic [2:0]  active_select;
        logic        transfer_done;
        logic [2:0]  done_slot;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

    // ring successor with wrap at any depth
    function automatic idx_t ring_next(input idx_t i);
        idx_t n;
        if (i == idx_t'(QUEUE_DEPTH - 1)) begin
            n = '0;
        end else begin
            n = i + idx_t'(1);
        end
        return n;
    endfunction

    // low three bits of a slot index, zero-extended for shallow rings
    function automatic logic [2:0] slot_low3(input idx_t i);
        logic [7:0] w;
        w = 8'(i);
        return w[2:0];
    endfunction

endpackage

// ===== rtl/spi_transfer_queue_sequencer.sv =====
// a result is valid on m_tvalid once its item has passed the capture registers and
// the output register; no new item is taken while one executes, as any update of
// the head descriptor is written back to ring memory in the following cycle
// a new item is taken only once the output register is empty or being drained
// reset (aresetn low, synchronous) clears head, tail, transmit enable, controller
// state and output valid; ring memory contents stay undefined until written
module spi_transfer_queue_sequencer
    import stq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // buffer_base[31:0], transfer_length[47:32], select_line[50:48],
    // received_byte[58:51], zero fill above
    input  logic [63:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // enqueue_accepted[0], queue_full[1], fetch_valid[2], fetch_address[34:3],
    // store_valid[35], store_address[67:36], store_data[75:68],
    // select_assert[76], select_release[77], active_select[80:78],
    // transfer_done[81], done_slot[84:82], zero fill above
    output logic [87:0] m_tdata
);

    cmd_t    cmd;
    status_t status;
    result_t result;

    stq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stq_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .in_operation       (op_t'(s_tuser)),
        .in_buffer_base     (s_tdata[31:0]),
        .in_transfer_length (s_tdata[47:32]),
        .in_select_line     (s_tdata[50:48]),
        .in_received_byte   (s_tdata[58:51]),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .result             (result)
    );

    // pack the result item, first field lowest
    assign m_tdata = {
        3'd0,
        result.done_slot,
        result.transfer_done,
        result.active_select,
        result.select_release,
        result.select_assert,
        result.store_data,
        result.store_address,
        result.store_valid,
        result.fetch_address,
        result.fetch_valid,
        result.queue_full,
        result.enqueue_accepted
    };

endmodule

// ===== rtl/stq_ctrl.sv =====
module stq_ctrl
    import stq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // take an item only when idle and the result slot will be free
    assign s_tready = (state_reg == ST_IDLE) && status.out_free;
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == ST_EXEC);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/stq_datapath.sv =====
module stq_datapath
    import stq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  op_t         in_operation,
    input  logic [31:0] in_buffer_base,
    input  logic [15:0] in_transfer_length,
    input  logic [2:0]  in_select_line,
    input  logic [7:0]  in_received_byte,
    input  logic        m_tready,
    output logic        m_tvalid,
    output result_t     result
);

    // ring memory of descriptors
    entry_t ring_mem [QUEUE_DEPTH];

    // captured item and head descriptor
    op_t         op_reg;
    logic [31:0] base_reg;
    logic [15:0] length_reg;
    logic [2:0]  sel_reg;
    logic [7:0]  rbyte_reg;
    entry_t      head_ent_reg;

    // ring control
    idx_t head_reg;
    idx_t head_next;
    idx_t tail_reg;
    idx_t tail_next;
    logic send_en_reg;
    logic send_en_next;

    // output register
    logic    m_valid_reg;
    result_t result_reg;
    result_t result_next;

    // memory write port
    logic   mem_we;
    idx_t   mem_waddr;
    entry_t mem_wdata;

    // working values
    logic        ring_empty;
    logic        do_fetch;
    logic [15:0] recv_inc;

    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign result = result_reg;

    // capture the item and read the head descriptor
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= in_operation;
            base_reg     <= in_buffer_base;
            length_reg   <= in_transfer_length;
            sel_reg      <= in_select_line;
            rbyte_reg    <= in_received_byte;
            head_ent_reg <= ring_mem[head_reg];
        end
    end

    // execute one item against the head descriptor
    always_comb begin
        result_next  = '0;
        head_next    = head_reg;
        tail_next    = tail_reg;
        send_en_next = send_en_reg;
        mem_we       = 1'b0;
        mem_waddr    = head_reg;
        mem_wdata    = head_ent_reg;
        ring_empty   = (head_reg == tail_reg);
        do_fetch     = 1'b0;
        recv_inc     = head_ent_reg.recv_pos + 16'd1;
        case (op_reg)
            OP_ENQUEUE: begin
                if (ring_next(tail_reg) != head_reg) begin
                    mem_we             = cmd.exec;
                    mem_waddr          = tail_reg;
                    mem_wdata.base     = base_reg;
                    mem_wdata.length   = length_reg;
                    mem_wdata.sel      = sel_reg;
                    mem_wdata.send_pos = '0;
                    mem_wdata.recv_pos = '0;
                    mem_wdata.active   = 1'b0;
                    tail_next          = ring_next(tail_reg);
                    send_en_next       = 1'b1;
                    result_next.enqueue_accepted = 1'b1;
                end else begin
                    result_next.queue_full = 1'b1;
                end
            end
            OP_TX_READY: begin
                if (send_en_reg) begin
                    if (ring_empty) begin
                        send_en_next = 1'b0;
                    end else if (head_ent_reg.send_pos == 16'd0) begin
                        // first byte: assert chip select
                        result_next.select_assert = 1'b1;
                        result_next.active_select = head_ent_reg.sel;
                        mem_wdata.active = 1'b1;
                        do_fetch = 1'b1;
                    end else if (head_ent_reg.send_pos >= head_ent_reg.length) begin
                        send_en_next = 1'b0;
                    end else begin
                        do_fetch = 1'b1;
                    end
                end
                if (do_fetch) begin
                    mem_we                    = cmd.exec;
                    mem_wdata.send_pos        = head_ent_reg.send_pos + 16'd1;
                    result_next.fetch_valid   = 1'b1;
                    result_next.fetch_address = head_ent_reg.base
                                              + {16'd0, head_ent_reg.send_pos};
                end
            end
            OP_RX_BYTE: begin
                if (ring_empty) begin
                    send_en_next = 1'b0;
                end else if (head_ent_reg.active) begin
                    mem_we                    = cmd.exec;
                    mem_wdata.recv_pos        = recv_inc;
                    result_next.store_valid   = 1'b1;
                    result_next.store_address = head_ent_reg.base
                                              + {16'd0, head_ent_reg.recv_pos};
                    result_next.store_data    = rbyte_reg;
                    // last byte: release select and retire the head
                    if (recv_inc >= head_ent_reg.length) begin
                        result_next.select_release = 1'b1;
                        result_next.active_select  = head_ent_reg.sel;
                        result_next.transfer_done  = 1'b1;
                        result_next.done_slot      = slot_low3(head_reg);
                        mem_wdata.active           = 1'b0;
                        head_next                  = ring_next(head_reg);
                        send_en_next               = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ring memory write
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
    end

    // ring control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            send_en_reg <= 1'b0;
        end else if (cmd.exec) begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            send_en_reg <= send_en_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            result_reg <= result_next;
        end
    end

    // a result carries at most one kind of action
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0({result_reg.enqueue_accepted, result_reg.queue_full,
                                  result_reg.fetch_valid, result_reg.store_valid}))
        else $error("result carries more than one action");

    // ring pointers move only when an item executes
    assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> $stable(head_reg) && $stable(tail_reg))
        else $error("ring pointer moved without an item");

    // a refused enqueue leaves the tail alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && result_next.queue_full) |=> $stable(tail_reg))
        else $error("tail moved on a full ring");

    // completion always releases chip select
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.transfer_done) |-> result_reg.select_release)
        else $error("transfer done without select release");

    // a new result is never loaded over one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> $past(status.out_free))
        else $error("result overwritten before taken");

endmodule
